### rtl/core/rcpc_pkg.sv
package rcpc_pkg;

    // Largest matrix side held in the column parity store
    localparam int MAX_SIZE = 128;

    localparam int CFG_W  = 8;
    localparam int FIX_W  = 8;
    localparam int POS_W  = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int SIZE_W = $clog2(MAX_SIZE + 1);

    // Tag queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    typedef enum logic [1:0] {
        VERDICT_OK  = 2'd0,
        VERDICT_FIX = 2'd1,
        VERDICT_BAD = 2'd2
    } t_verdict;

    // One classified cell
    typedef struct packed {
        logic             cell_bit;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             first_row;
        logic             row_end;
        logic             mat_end;
    } t_tag;

    typedef struct packed {
        logic push;
        t_tag tag;
    } t_qwr;

    typedef struct packed {
        logic vld;
        t_tag tag;
    } t_qrd;

    // Zero reads as one, anything above the store depth as the depth
    function automatic logic [SIZE_W-1:0] eff_size(input logic [CFG_W-1:0] cfg);
        logic [SIZE_W-1:0] s;
        if (cfg == '0) begin
            s = SIZE_W'(1);
        end else if (int'(cfg) > MAX_SIZE) begin
            s = SIZE_W'(MAX_SIZE);
        end else begin
            s = SIZE_W'(cfg);
        end
        return s;
    endfunction

endpackage

### rtl/core/rcpc_cell_if.sv
interface rcpc_cell_if;
    logic valid;
    logic ready;
    logic cell_bit;

    modport source (output valid, output cell_bit, input ready);
    modport sink   (input valid, input cell_bit, output ready);
endinterface

### rtl/core/rcpc_res_if.sv
interface rcpc_res_if;
    import rcpc_pkg::*;

    logic             valid;
    logic             ready;
    t_verdict         verdict;
    logic [FIX_W-1:0] fix_row;
    logic [FIX_W-1:0] fix_col;

    modport source (output valid, output verdict, output fix_row, output fix_col, input ready);
    modport sink   (input valid, input verdict, input fix_row, input fix_col, output ready);
endinterface

### rtl/core/rcpc_front.sv
module rcpc_front (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rcpc_pkg::CFG_W-1:0] i_cfg_data,
    rcpc_cell_if.sink                  i_cell,
    input  logic                       i_full,
    output rcpc_pkg::t_qwr             o_qwr
);
    import rcpc_pkg::*;

    localparam int CMP_W = SIZE_W + 1;

    logic [SIZE_W-1:0] r_size;
    logic [POS_W-1:0]  r_col;
    logic [POS_W-1:0]  r_row;

    logic [CMP_W-1:0] col_nx;
    logic [CMP_W-1:0] row_nx;
    logic             col_last;
    logic             row_last;
    logic             accept;

    // Position compare against the effective side
    assign col_nx   = CMP_W'(r_col) + CMP_W'(1);
    assign row_nx   = CMP_W'(r_row) + CMP_W'(1);
    assign col_last = col_nx >= CMP_W'(r_size);
    assign row_last = row_nx >= CMP_W'(r_size);

    assign i_cell.ready = !i_full;
    assign accept       = i_cell.valid && !i_full;

    // Tag for the back end
    always_comb begin
        o_qwr.push          = accept;
        o_qwr.tag.cell_bit  = i_cell.cell_bit;
        o_qwr.tag.col       = r_col;
        o_qwr.tag.row       = r_row;
        o_qwr.tag.first_row = (r_row == '0);
        o_qwr.tag.row_end   = col_last;
        o_qwr.tag.mat_end   = col_last && row_last;
    end

    // Size register and raster position
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size <= eff_size(CFG_W'(8));
            r_col  <= '0;
            r_row  <= '0;
        end else if (i_cfg_we) begin
            r_size <= eff_size(i_cfg_data);
            r_col  <= '0;
            r_row  <= '0;
        end else if (accept) begin
            if (col_last) begin
                r_col <= '0;
                r_row <= row_last ? '0 : POS_W'(row_nx);
            end else begin
                r_col <= POS_W'(col_nx);
            end
        end
    end

endmodule

### rtl/core/rcpc_fifo.sv
module rcpc_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  rcpc_pkg::t_qwr i_qwr,
    input  logic           i_pop,
    output logic           o_full,
    output rcpc_pkg::t_qrd o_qrd
);
    import rcpc_pkg::*;

    t_tag              r_ent [QDEPTH];
    logic [QPTR_W-1:0] r_wptr;
    logic [QPTR_W-1:0] r_rptr;
    logic [QPTR_W:0]   r_cnt;

    logic do_push;
    logic do_pop;

    assign o_full    = (r_cnt == (QPTR_W+1)'(QDEPTH));
    assign o_qrd.vld = (r_cnt != '0);
    assign o_qrd.tag = r_ent[r_rptr];

    assign do_push = i_qwr.push && !o_full;
    assign do_pop  = i_pop && o_qrd.vld;

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_ent[r_wptr] <= i_qwr.tag;
        end
    end

    // Pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (do_push) begin
                r_wptr <= r_wptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rptr <= r_rptr + QPTR_W'(1);
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + (QPTR_W+1)'(1);
                2'b01:   r_cnt <= r_cnt - (QPTR_W+1)'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

### rtl/core/rcpc_back.sv
module rcpc_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_clr,
    input  rcpc_pkg::t_qrd i_qrd,
    output logic           o_pop,
    rcpc_res_if.source     o_res
);
    import rcpc_pkg::*;

    // Column parity store, one bit per column
    logic             r_mem [MAX_SIZE];
    logic             r_rd;

    logic             r_s2_valid;
    t_tag             r_s2;

    // Running accumulation
    logic             r_rpar;
    logic [SIZE_W-1:0] r_ccnt;
    logic [POS_W-1:0] r_cx;
    logic [1:0]       r_orc;
    logic [POS_W-1:0] r_lrow;

    logic             r_out_valid;
    t_verdict         r_verdict;
    logic [FIX_W-1:0] r_fix_row;
    logic [FIX_W-1:0] r_fix_col;

    logic             stall;
    logic             adv;
    logic             old_par;
    logic             new_par;
    logic             n_rpar;
    logic [SIZE_W-1:0] n_ccnt;
    logic [POS_W-1:0] n_cx;
    logic [1:0]       n_orc;
    logic [POS_W-1:0] n_lrow;
    logic [POS_W:0]   row1;
    logic [POS_W:0]   col1;
    t_verdict         n_verdict;
    logic [FIX_W-1:0] n_fix_row;
    logic [FIX_W-1:0] n_fix_col;

    // Hold the last cell of a matrix while the previous verdict is unclaimed
    assign stall = r_s2_valid && r_s2.mat_end && r_out_valid && !o_res.ready;
    assign adv   = r_s2_valid && !stall;
    assign o_pop = i_qrd.vld && !stall;

    // First row starts every column afresh
    assign old_par = r_s2.first_row ? 1'b0 : r_rd;
    assign new_par = old_par ^ r_s2.cell_bit;

    // Next accumulation and verdict
    always_comb begin
        n_rpar = r_rpar ^ r_s2.cell_bit;
        n_ccnt = r_ccnt;
        n_cx   = r_cx;
        n_orc  = r_orc;
        n_lrow = r_lrow;
        if (r_s2.cell_bit) begin
            n_ccnt = old_par ? (r_ccnt - SIZE_W'(1)) : (r_ccnt + SIZE_W'(1));
            n_cx   = r_cx ^ r_s2.col;
        end
        if (r_s2.row_end && n_rpar) begin
            n_orc  = (r_orc == 2'd2) ? 2'd2 : (r_orc + 2'd1);
            n_lrow = r_s2.row;
        end
        row1 = {1'b0, n_lrow} + (POS_W+1)'(1);
        col1 = {1'b0, n_cx} + (POS_W+1)'(1);
        n_fix_row = '0;
        n_fix_col = '0;
        if (n_orc == 2'd0 && n_ccnt == '0) begin
            n_verdict = VERDICT_OK;
        end else if (n_orc == 2'd1 && n_ccnt == SIZE_W'(1)) begin
            n_verdict = VERDICT_FIX;
            n_fix_row = FIX_W'(row1);
            n_fix_col = FIX_W'(col1);
        end else begin
            n_verdict = VERDICT_BAD;
        end
    end

    // Store write-back and read with bypass of the beat being written
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mem[r_s2.col] <= new_par;
        end
        if (o_pop) begin
            if (adv && r_s2.col == i_qrd.tag.col) begin
                r_rd <= new_par;
            end else begin
                r_rd <= r_mem[i_qrd.tag.col];
            end
        end
    end

    // Working stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_s2_valid <= 1'b0;
        end else if (o_pop) begin
            r_s2_valid <= 1'b1;
        end else if (adv) begin
            r_s2_valid <= 1'b0;
        end
        if (o_pop) begin
            r_s2 <= i_qrd.tag;
        end
    end

    // Accumulators: row parity cleared at each row end, all cleared at matrix end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clr) begin
            r_rpar <= 1'b0;
            r_ccnt <= '0;
            r_cx   <= '0;
            r_orc  <= '0;
            r_lrow <= '0;
        end else if (adv) begin
            if (r_s2.mat_end) begin
                r_rpar <= 1'b0;
                r_ccnt <= '0;
                r_cx   <= '0;
                r_orc  <= '0;
                r_lrow <= '0;
            end else begin
                r_rpar <= r_s2.row_end ? 1'b0 : n_rpar;
                r_ccnt <= n_ccnt;
                r_cx   <= n_cx;
                r_orc  <= n_orc;
                r_lrow <= n_lrow;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_s2.mat_end) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
        if (adv && r_s2.mat_end) begin
            r_verdict <= n_verdict;
            r_fix_row <= n_fix_row;
            r_fix_col <= n_fix_col;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.verdict = r_verdict;
    assign o_res.fix_row = r_fix_row;
    assign o_res.fix_col = r_fix_col;

endmodule

### rtl/core/row_column_parity_checker.sv
// Two-dimensional parity check over a square bit matrix.
// i_cell carries one cell per beat in row-major order; only cell_bit counts.
// o_res carries one verdict per matrix: VERDICT_OK, VERDICT_FIX with the
// 1-based fix_row/fix_col of the single flipped bit, or VERDICT_BAD.
// i_cfg_we/i_cfg_data set the matrix side (0 acts as 1, values above
// MAX_SIZE act as MAX_SIZE) and drop any partial matrix; write only when idle.
// Throughput: one cell per cycle, back to back across matrices, while no held
// verdict stalls the back end. The front end tracks row/column position and
// tags each cell; a four-entry tag queue feeds the back end, which does a
// read-modify-write of the column parity store for each cell and keeps running
// counts of odd rows and odd columns. The verdict leaves an output register.
// Reset: side returns to 8, all accumulation cleared, queue and output empty.
// Stall: a held verdict keeps o_res stable; the back end stops at the next
// matrix's last cell, and i_cell.ready drops once the tag queue fills.
module row_column_parity_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rcpc_pkg::CFG_W-1:0] i_cfg_data,
    rcpc_cell_if.sink                  i_cell,
    rcpc_res_if.source                 o_res
);
    import rcpc_pkg::*;

    t_qwr qwr;
    t_qrd qrd;
    logic q_full;
    logic q_pop;

    rcpc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_cell     (i_cell),
        .i_full     (q_full),
        .o_qwr      (qwr)
    );

    rcpc_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qwr   (qwr),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_qrd   (qrd)
    );

    rcpc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clr   (i_cfg_we),
        .i_qrd   (qrd),
        .o_pop   (q_pop),
        .o_res   (o_res)
    );

endmodule
